// ===== rtl/dht_pkg.sv =====
// Package of the double hashing table: sizes, codes, types and the
// constant hash tables. Depends on nothing; every other file imports it.
package dht_pkg;

	localparam int SLOTS       = 128;
	localparam int VALUE_WIDTH = 16;

	localparam int KEY_W      = 8;
	localparam int DATA_W     = 16;
	localparam int SLOT_OUT_W = 7;
	localparam int IDX_W      = $clog2(SLOTS);
	localparam int KEY_RANGE  = 2 ** KEY_W;

	typedef logic [KEY_W-1:0]       key_t;
	typedef logic [DATA_W-1:0]      data_t;
	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [SLOT_OUT_W-1:0]  slot_out_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_SEARCH = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STS_DONE     = 2'd0,
		STS_MISS     = 2'd1,
		STS_OVERFLOW = 2'd2,
		STS_BAD_KEY  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_PROBE
	} fsm_t;

	typedef struct packed {
		key_t   key;
		value_t value;
	} entry_t;

	typedef idx_t hash_tab_t [KEY_RANGE];

	localparam key_t EMPTY_KEY = '0;

	// Home slot of a key: key mod SLOTS.
	function automatic hash_tab_t build_home_tab();
		hash_tab_t t;
		for (int k = 0; k < KEY_RANGE; k++) begin
			t[k] = IDX_W'(k % SLOTS);
		end
		return t;
	endfunction

	// Probe stride of a key: 1 + key mod (SLOTS - 1).
	function automatic hash_tab_t build_step_tab();
		hash_tab_t t;
		for (int k = 0; k < KEY_RANGE; k++) begin
			t[k] = IDX_W'(1 + k % (SLOTS - 1));
		end
		return t;
	endfunction

	localparam hash_tab_t HOME_TAB = build_home_tab();
	localparam hash_tab_t STEP_TAB = build_step_tab();

endpackage

// ===== rtl/dht_req_if.sv =====
// Request channel of the double hashing table: valid, ready and the
// request fields. Depends on dht_pkg.
interface dht_req_if;
	import dht_pkg::*;

	logic  valid;
	logic  ready;
	op_t   op;
	key_t  key;
	data_t value;

	modport source (output valid, output op, output key, output value, input ready);
	modport sink (input valid, input op, input key, input value, output ready);
endinterface

// ===== rtl/dht_resp_if.sv =====
// Response channel of the double hashing table: valid, ready and the
// result fields. Depends on dht_pkg.
interface dht_resp_if;
	import dht_pkg::*;

	logic      valid;
	logic      ready;
	status_t   status;
	data_t     found_value;
	slot_out_t slot_index;

	modport source (output valid, output status, output found_value, output slot_index,
		input ready);
	modport sink (input valid, input status, input found_value, input slot_index,
		output ready);
endinterface

// ===== rtl/double_hash_table.sv =====
// Top level of the double hashing table: slot memory, probe sequencer and
// response register. Depends on dht_pkg, dht_req_if and dht_resp_if.
//
//   channel   direction   payload
//   req       in          op, key, value
//   resp      out         status, found_value, slot_index
//
// A request is accepted in the idle state and then probes one slot at a time, each probe
// being one read of the single port slot memory; a bad key ends the probing at once.
// After reset a clearing pass writes every slot empty, with req.ready low.
// A finished result waits in the response register while the next request is
// accepted; the probe sequencer holds its last probe until that register is free.
module double_hash_table (
	input  logic     clk,
	input  logic     arst_n,
	dht_req_if.sink   req,
	dht_resp_if.source resp
);
	import dht_pkg::*;

	entry_t slot_mem [SLOTS];
	entry_t rd_data_q;

	fsm_t      state_q, state_d;
	idx_t      clr_cnt_q;
	op_t       op_q;
	key_t      key_q;
	value_t    value_q;
	logic      bad_q;
	idx_t      idx_q, step_q, cnt_q;

	logic      out_valid_q;
	status_t   out_status_q;
	data_t     out_value_q;
	slot_out_t out_slot_q;

	idx_t      rd_addr;
	logic      mem_we;
	idx_t      mem_wa;
	entry_t    mem_wd;
	logic      accept;
	logic      advance;
	logic      probe_end;
	logic      out_load;
	logic      out_free;
	status_t   res_status;
	data_t     res_value;
	slot_out_t res_slot;
	idx_t      idx_next;
	logic [IDX_W:0] idx_sum;
	logic      is_match, is_empty, is_last;

	assign out_free = !out_valid_q || resp.ready;
	assign is_match = rd_data_q.key == key_q;
	assign is_empty = rd_data_q.key == EMPTY_KEY;
	assign is_last  = cnt_q == IDX_W'(SLOTS - 1);
	assign idx_sum  = {1'b0, idx_q} + {1'b0, step_q};
	assign idx_next = (idx_sum >= (IDX_W + 1)'(SLOTS)) ?
		IDX_W'(idx_sum - (IDX_W + 1)'(SLOTS)) : IDX_W'(idx_sum);

	always_comb begin
		probe_end  = 1'b0;
		res_status = STS_DONE;
		res_value  = '0;
		res_slot   = '0;
		if (bad_q) begin
			probe_end  = 1'b1;
			res_status = STS_BAD_KEY;
		end else if (op_q == OP_INSERT) begin
			if (is_empty || is_match) begin
				probe_end = 1'b1;
				res_slot  = SLOT_OUT_W'(idx_q);
			end else if (is_last) begin
				probe_end  = 1'b1;
				res_status = STS_OVERFLOW;
			end
		end else begin
			if (is_match) begin
				probe_end = 1'b1;
				res_value = DATA_W'(rd_data_q.value);
				res_slot  = SLOT_OUT_W'(idx_q);
			end else if (is_empty || is_last) begin
				probe_end  = 1'b1;
				res_status = STS_MISS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		accept    = 1'b0;
		advance   = 1'b0;
		out_load  = 1'b0;
		rd_addr   = idx_q;
		mem_we    = 1'b0;
		mem_wa    = idx_q;
		mem_wd    = '{key: key_q, value: value_q};
		unique case (state_q)
			FSM_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_cnt_q;
				mem_wd = '{key: EMPTY_KEY, value: '0};
				if (clr_cnt_q == IDX_W'(SLOTS - 1)) begin
					state_d = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				req.ready = 1'b1;
				rd_addr   = HOME_TAB[req.key];
				if (req.valid) begin
					accept  = 1'b1;
					state_d = FSM_PROBE;
				end
			end
			FSM_PROBE: begin
				if (!probe_end) begin
					advance = 1'b1;
					rd_addr = idx_next;
				end else if (out_free) begin
					out_load = 1'b1;
					mem_we   = !bad_q && op_q == OP_INSERT && res_status == STS_DONE;
					state_d  = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_wa] <= mem_wd;
		end else begin
			rd_data_q <= slot_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (state_q == FSM_CLEAR) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.op;
			key_q   <= req.key;
			value_q <= VALUE_WIDTH'(req.value);
			bad_q   <= req.key == EMPTY_KEY;
			idx_q   <= HOME_TAB[req.key];
			step_q  <= STEP_TAB[req.key];
			cnt_q   <= '0;
		end else if (advance) begin
			idx_q <= idx_next;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (resp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status;
			out_value_q  <= res_value;
			out_slot_q   <= res_slot;
		end
	end

	assign resp.valid       = out_valid_q;
	assign resp.status      = out_status_q;
	assign resp.found_value = out_value_q;
	assign resp.slot_index  = out_slot_q;

	// Only the clearing pass and a finished insert may write the slot memory.
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == FSM_CLEAR) ||
		(state_q == FSM_PROBE && op_q == OP_INSERT && !bad_q && out_load))
		else $error("slot memory written outside clearing or insert");

	// A probe that does not end moves on to the next slot of the sequence.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_PROBE && !probe_end) |=>
		(state_q == FSM_PROBE && cnt_q == IDX_W'($past(cnt_q) + 1'b1)))
		else $error("probe counter did not advance");

	// A result is only loaded when the response register is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (state_q == FSM_PROBE && (!out_valid_q || resp.ready)))
		else $error("response register overwritten");

endmodule

// ===== sim/double_hash_table_checker.sv =====
`timescale 1ns / 1ps
// Checker of the double hashing table: keeps its own copy of the slot keys and
// values, predicts the response to every request and compares every field of it.
// Depends on dht_pkg and the request and response interfaces.
module double_hash_table_checker (
	input  logic clk,
	input  logic arst_n,
	dht_req_if   req,
	dht_resp_if  resp,
	output int   errors,
	output int   pending
);
	import dht_pkg::*;

	typedef struct packed {
		status_t   status;
		data_t     found_value;
		slot_out_t slot_index;
	} reply_t;

	key_t   slot_key [SLOTS];
	value_t slot_val [SLOTS];
	reply_t due_replies [$];
	reply_t got;
	reply_t want;

	function automatic reply_t probe_table(op_t op, key_t key, data_t value);
		reply_t r;
		int     slot;
		int     stride;
		r.status      = (op == OP_INSERT) ? STS_OVERFLOW : STS_MISS;
		r.found_value = '0;
		r.slot_index  = '0;
		if (key == EMPTY_KEY) begin
			r.status = STS_BAD_KEY;
			return r;
		end
		slot   = int'(key) % SLOTS;
		stride = 1 + int'(key) % (SLOTS - 1);
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_key[slot] == key || slot_key[slot] == EMPTY_KEY) begin
				if (op == OP_INSERT) begin
					slot_key[slot] = key;
					slot_val[slot] = value_t'(value);
					r.status       = STS_DONE;
					r.slot_index   = slot_out_t'(slot);
				end else if (slot_key[slot] == key) begin
					r.status       = STS_DONE;
					r.found_value  = data_t'(slot_val[slot]);
					r.slot_index   = slot_out_t'(slot);
				end
				return r;
			end
			slot = (slot + stride) % SLOTS;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (slot_key[i])
				slot_key[i] = EMPTY_KEY;
			due_replies.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (resp.valid && resp.ready) begin
				got = '{resp.status, resp.found_value, resp.slot_index};
				if (due_replies.size() == 0) begin
					$display("%0t: response with no request waiting: status %0d value %h slot %0d",
						$time, got.status, got.found_value, got.slot_index);
					errors <= errors + 1;
				end else begin
					want = due_replies.pop_front();
					if (got !== want) begin
						$display("%0t: expected status %0d value %h slot %0d, actual status %0d value %h slot %0d",
							$time, want.status, want.found_value, want.slot_index,
							got.status, got.found_value, got.slot_index);
						errors <= errors + 1;
					end
				end
			end
			if (req.valid && req.ready)
				due_replies.push_back(probe_table(req.op, req.key, req.value));
			pending <= due_replies.size();
		end
	end

endmodule

// ===== sim/double_hash_table_test.sv =====
`timescale 1ns / 1ps
// Testbench top of the double hashing table: clock, reset, request and response
// stimulus with random gaps and a long stall, watchdog and verdict.
// Depends on dht_pkg, the two interfaces, the block and double_hash_table_checker.
module double_hash_table_test;
	import dht_pkg::*;

	localparam int RANDOM_ITEMS = 1330;
	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   sent = 0;
	int   errors;
	int   pending;
	int   stall = 0;
	bit   held = 1'b0;
	wire  calm = (sent >= 720) && (sent < 1020);

	dht_req_if  req();
	dht_resp_if resp();

	double_hash_table DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.resp   (resp)
	);

	double_hash_table_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.resp    (resp),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic send_request(input op_t op, input key_t key, input data_t value);
		req.valid <= 1'b1;
		req.op    <= op;
		req.key   <= key;
		req.value <= value;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sent <= sent + 1;
	endtask

	task automatic idle_cycles(input int n);
		req.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	initial begin
		resp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && sent >= 300) begin
				held = 1'b1;
				resp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			resp.ready <= calm || ($urandom_range(99) >= 7);
		end
	end

	initial begin
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (resp.valid && resp.ready))
				stall = 0;
			else
				stall = stall + 1;
		end
		$display("double_hash_table_test: FAIL");
		$finish;
	end

	initial begin
		op_t   op;
		key_t  key;
		data_t value;
		int    top_key;
		req.valid <= 1'b0;
		req.op    <= OP_INSERT;
		req.key   <= EMPTY_KEY;
		req.value <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests: misses, bad keys, collisions, overwrites, and a key
		// whose short probe cycle is fully occupied by other keys.
		send_request(OP_SEARCH, 8'd5,   16'h0000);
		send_request(OP_INSERT, 8'd0,   16'hFFFF);
		send_request(OP_SEARCH, 8'd0,   16'hFFFF);
		send_request(OP_INSERT, 8'd1,   16'h0000);
		send_request(OP_INSERT, 8'd127, 16'h5555);
		send_request(OP_INSERT, 8'd255, 16'hFFFF);
		send_request(OP_INSERT, 8'd129, 16'hAAAA);
		send_request(OP_INSERT, 8'd128, 16'h1234);
		send_request(OP_INSERT, 8'd254, 16'h8001);
		send_request(OP_INSERT, 8'd1,   16'hA5A5);
		send_request(OP_SEARCH, 8'd1,   16'h0000);
		send_request(OP_SEARCH, 8'd255, 16'h0000);
		send_request(OP_SEARCH, 8'd129, 16'h0000);
		send_request(OP_SEARCH, 8'd128, 16'h0000);
		send_request(OP_SEARCH, 8'd127, 16'h0000);
		send_request(OP_SEARCH, 8'd254, 16'h0000);
		send_request(OP_SEARCH, 8'd200, 16'h0000);
		send_request(OP_INSERT, 8'd191, 16'h0F0F);
		send_request(OP_INSERT, 8'd63,  16'hF0F0);
		send_request(OP_SEARCH, 8'd63,  16'h0000);
		send_request(OP_SEARCH, 8'd191, 16'h0000);
		send_request(OP_INSERT, 8'd191, 16'hFFFF);
		send_request(OP_SEARCH, 8'd191, 16'h0000);

		// The key range grows slowly so the table passes through every fill level.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			top_key = (i / 4 + 4 > 255) ? 255 : i / 4 + 4;
			op      = op_t'($urandom_range(1));
			key     = ($urandom_range(99) < 3) ? EMPTY_KEY : key_t'($urandom_range(top_key, 1));
			value   = data_t'($urandom);
			if (i == 500)
				drain();
			if (!calm && $urandom_range(99) < 7)
				idle_cycles($urandom_range(4, 1));
			send_request(op, key, value);
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("double_hash_table_test: PASS");
		else
			$display("double_hash_table_test: FAIL");
		$finish;
	end

endmodule
